### design/multi_sequence_cell_traversal_unit_defines.svh
// ----------------------------------------------------------------------------
// multi_sequence_cell_traversal_unit_defines
// Assertion macros shared by the traversal unit and its heap.
// ----------------------------------------------------------------------------
`ifndef MULTI_SEQUENCE_CELL_TRAVERSAL_UNIT_DEFINES_SVH
`define MULTI_SEQUENCE_CELL_TRAVERSAL_UNIT_DEFINES_SVH

`ifndef SYNTH
// property that holds at every clock edge
`define MSCT_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("msct check failed");
// property whose consequence holds in the cycle after its antecedent
`define MSCT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msct check failed");
`else
`define MSCT_CHECK(lbl, expr)
`define MSCT_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### design/msct_pkg.sv
// ----------------------------------------------------------------------------
// msct_pkg
// Types, codes and default sizes of the multi-sequence cell traversal unit.
// ----------------------------------------------------------------------------
package msct_pkg;

  // default sizes
  localparam int NUM_SUBQ_DEF       = 2;
  localparam int NUM_CLUSTERS_DEF   = 16;
  localparam int ENTRY_DEPTH_DEF    = 1024;
  localparam int MAX_CANDIDATES_DEF = 64;

  // fixed field widths
  localparam int DIST_W  = 16;
  localparam int ADDR_W  = 11;
  localparam int ENTRY_W = 32;
  localparam int WANT_W  = 7;

  // input modes
  localparam logic [2:0] MODE_DIST  = 3'd0;
  localparam logic [2:0] MODE_ORDER = 3'd1;
  localparam logic [2:0] MODE_LIST  = 3'd2;
  localparam logic [2:0] MODE_ENTRY = 3'd3;
  localparam logic [2:0] MODE_START = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         subq_row;
    logic [7:0]         rank_column;
    logic [DIST_W-1:0]  distance_value;
    logic [7:0]         cluster_id;
    logic [ADDR_W-1:0]  table_address;
    logic [ADDR_W-1:0]  list_offset;
    logic [ENTRY_W-1:0] entry_value;
    logic [WANT_W-1:0]  want_count;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] candidate;
    logic               last;
    logic               exhausted;
  } out_t;

  // traversal sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_SEED, S_TW_RD, S_TW_ACC, S_PUSH, S_PUSH_WAIT, S_LOOP,
    S_POP, S_POP_WAIT, S_MARK, S_LS_RD, S_LS_WAIT, S_EMIT_CHK, S_ENT_RD,
    S_ENT_WAIT, S_NB_CHK, S_VS_RD, S_VS_CHK, S_NB_NEXT, S_END_MARK
  } st_t;

  // heap states
  typedef enum logic [2:0] {
    H_IDLE, H_POP_RD, H_POP_LD, H_DN_RD, H_DN_CMP, H_UP_RD, H_UP_CMP
  } hst_t;

  // heap command and status
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } hreq_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } hstat_t;

endpackage

### design/msct_heap.sv
// ----------------------------------------------------------------------------
// msct_heap
// Binary min-heap of cells ordered by summed distance, then by cell index.
// One memory with two read ports; sifts move a hole, one level per read and compare step.
// ----------------------------------------------------------------------------
`include "multi_sequence_cell_traversal_unit_defines.svh"

module msct_heap #(
  parameter int NUM_SUBQ     = msct_pkg::NUM_SUBQ_DEF,
  parameter int NUM_CLUSTERS = msct_pkg::NUM_CLUSTERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  msct_pkg::hreq_t                       req,
  input  logic [msct_pkg::DIST_W+$clog2(NUM_SUBQ)-1:0] key_in,
  input  logic [NUM_SUBQ*$clog2(NUM_CLUSTERS)-1:0]     cell_in,
  output msct_pkg::hstat_t                      stat,
  output logic [NUM_SUBQ*$clog2(NUM_CLUSTERS)-1:0]     top_cell
);
  import msct_pkg::*;

  localparam int RW     = $clog2(NUM_CLUSTERS);
  localparam int CELL_W = NUM_SUBQ * RW;
  localparam int KEY_W  = DIST_W + $clog2(NUM_SUBQ);
  localparam int ENT_W  = KEY_W + CELL_W;
  localparam int DEPTH  = NUM_CLUSTERS ** NUM_SUBQ;
  localparam int HW     = $clog2(DEPTH);

  hst_t state, state_next;

  logic [ENT_W-1:0] heap_mem [DEPTH];
  logic [ENT_W-1:0] rd_a, rd_b, item;
  logic [HW:0]      size;
  logic [HW-1:0]    hole;

  logic [HW-1:0]    raddr_a, raddr_b, waddr, parent, midx;
  logic [ENT_W-1:0] wdata, mval;
  logic             we, use_r, mless, up_less;
  logic [HW+1:0]    l_ext, r_ext, size_ext;

  // child and parent positions of the hole
  assign l_ext    = {1'b0, hole, 1'b1};
  assign r_ext    = l_ext + 1'b1;
  assign size_ext = {1'b0, size};
  assign parent   = HW'((hole - 1'b1) >> 1);
  assign use_r    = (r_ext < size_ext) && (rd_b < rd_a);
  assign mval     = use_r ? rd_b : rd_a;
  assign midx     = use_r ? HW'(r_ext) : HW'(l_ext);
  assign mless    = mval < item;
  assign up_less  = item < rd_a;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      H_IDLE: begin
        if (req.push) state_next = H_UP_RD;
        else if (req.pop) state_next = H_POP_RD;
      end
      H_POP_RD: state_next = H_POP_LD;
      H_POP_LD: state_next = (size == (HW+1)'(1)) ? H_IDLE : H_DN_RD;
      H_DN_RD:  state_next = (l_ext < size_ext) ? H_DN_CMP : H_IDLE;
      H_DN_CMP: state_next = mless ? H_DN_RD : H_IDLE;
      H_UP_RD:  state_next = (hole == '0) ? H_IDLE : H_UP_CMP;
      H_UP_CMP: state_next = up_less ? H_UP_RD : H_IDLE;
      default:  state_next = H_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    waddr   = hole;
    wdata   = item;
    case (state)
      H_POP_RD: begin
        raddr_a = '0;
        raddr_b = HW'(size - 1'b1);
      end
      H_DN_RD: begin
        raddr_a = HW'(l_ext);
        raddr_b = (r_ext < size_ext) ? HW'(r_ext) : HW'(l_ext);
        we      = !(l_ext < size_ext);
      end
      H_DN_CMP: begin
        we    = 1'b1;
        wdata = mless ? mval : item;
      end
      H_UP_RD: begin
        raddr_a = parent;
        we      = (hole == '0);
      end
      H_UP_CMP: begin
        we    = 1'b1;
        wdata = up_less ? rd_a : item;
      end
      default: ;
    endcase
  end

  assign stat.busy  = (state != H_IDLE);
  assign stat.empty = (size == '0);

  // heap storage
  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    rd_a <= heap_mem[raddr_a];
    rd_b <= heap_mem[raddr_b];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      size  <= '0;
    end else begin
      state <= state_next;
      if (state == H_IDLE && req.clear) size <= '0;
      else if (state == H_IDLE && req.push) size <= size + 1'b1;
      else if (state == H_POP_LD) size <= size - 1'b1;
    end
  end

  // hole and carried item
  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (req.push) begin
          item <= {key_in, cell_in};
          hole <= HW'(size);
        end
      end
      H_POP_LD: begin
        top_cell <= rd_a[CELL_W-1:0];
        item     <= rd_b;
        hole     <= '0;
      end
      H_DN_CMP: if (mless) hole <= midx;
      H_UP_CMP: if (up_less) hole <= parent;
      default: ;
    endcase
  end

  `MSCT_CHECK(a_heap_cmd_idle, !(req.push || req.pop) || state == H_IDLE)
  `MSCT_CHECK(a_heap_bound, 32'(size) <= DEPTH)
  `MSCT_CHECK_NEXT(a_heap_pop_shrink, state == H_POP_LD, size == $past(size) - 1'b1)

endmodule

### design/multi_sequence_cell_traversal_unit.sv
// ----------------------------------------------------------------------------
// multi_sequence_cell_traversal_unit
// Multi-sequence walk over the cells of an inverted multi-index.
// ----------------------------------------------------------------------------
// Load beats (distance, cluster order, list start, entry) are taken one per
// cycle while the unit is idle; each in-range beat writes one table entry. A
// start beat with a nonzero want count clears the visited map, one entry a
// cycle (NUM_CLUSTERS rounded up to a power of two, to the power NUM_SUBQ:
// 256 entries by default), and then walks cells in ascending summed distance
// through a min-heap. Per popped cell come the heap pop, the table walk over
// each subquantizer, an entry memory read plus output register per emitted
// candidate, and per neighbor test the visited-map reads plus a heap push.
// The visited map, the heap and the table reads are the limiting paths; no
// new beat is taken until the walk has loaded its final result. A query that
// runs out of cells ends with a marker beat that has last and exhausted set.
// ----------------------------------------------------------------------------
`include "multi_sequence_cell_traversal_unit_defines.svh"

module multi_sequence_cell_traversal_unit #(
  parameter int NUM_SUBQ       = msct_pkg::NUM_SUBQ_DEF,
  parameter int NUM_CLUSTERS   = msct_pkg::NUM_CLUSTERS_DEF,
  parameter int ENTRY_DEPTH    = msct_pkg::ENTRY_DEPTH_DEF,
  parameter int MAX_CANDIDATES = msct_pkg::MAX_CANDIDATES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  msct_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output msct_pkg::out_t out_data
);
  import msct_pkg::*;

  localparam int RW     = $clog2(NUM_CLUSTERS);
  localparam int ROWW   = $clog2(NUM_SUBQ);
  localparam int DW     = $clog2(NUM_SUBQ + 1);
  localparam int CELL_W = NUM_SUBQ * RW;
  localparam int VCELLS = 2 ** CELL_W;
  localparam int NCELLS = NUM_CLUSTERS ** NUM_SUBQ;
  localparam int LSW    = $clog2(NCELLS + 1);
  localparam int EW     = $clog2(ENTRY_DEPTH);
  localparam int KEY_W  = DIST_W + $clog2(NUM_SUBQ);
  localparam int CW     = $clog2(MAX_CANDIDATES + 1);
  localparam int TW_A   = ROWW + RW;

  st_t state, state_next;

  // tables
  logic [DIST_W-1:0]  dist_mem  [2 ** TW_A];
  logic [RW-1:0]      ord_mem   [2 ** TW_A];
  logic [ADDR_W-1:0]  ls_mem    [NCELLS + 1];
  logic [ENTRY_W-1:0] ent_mem   [ENTRY_DEPTH];
  logic               vis_mem   [VCELLS];

  logic [DIST_W-1:0]  dist_rd;
  logic [RW-1:0]      ord_rd;
  logic [ADDR_W-1:0]  ls_rd_a, ls_rd_b;
  logic [ENTRY_W-1:0] ent_rd;
  logic               vis_rd;

  // walk registers
  logic [CELL_W:0]    clr_addr;
  logic [CELL_W-1:0]  walk_cell, cur_cell, nb_cell;
  logic [DW-1:0]      dsel, esel, nb_d;
  logic [KEY_W-1:0]   sum;
  logic [LSW-1:0]     p_acc;
  logic [ADDR_W-1:0]  ptr, stop;
  logic [CW-1:0]      emitted, want_cnt;
  logic               for_pop, seeding;

  // heap link
  hreq_t              hreq;
  hstat_t             hstat;
  logic [CELL_W-1:0]  pop_cell;

  // decoded signals
  logic               accept, slot_free, is_load, emit_ok, rank_room, nb_last, e_last;
  logic [RW-1:0]      wrank [NUM_SUBQ];
  logic [RW-1:0]      crank [NUM_SUBQ];
  logic [RW-1:0]      nrank [NUM_SUBQ];
  logic [CELL_W-1:0]  unit_d, unit_e, vis_raddr, vis_waddr;
  logic               vis_we, vis_wdata, tw_last;
  logic [TW_A-1:0]    tw_addr;
  logic [CW-1:0]      want_sat;
  logic [LSW-1:0]     ls_addr_b;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // rank fields of the packed cells, subquantizer 0 most significant
  always_comb begin
    for (int k = 0; k < NUM_SUBQ; k++) begin
      wrank[k] = walk_cell[(NUM_SUBQ-1-k)*RW +: RW];
      crank[k] = cur_cell[(NUM_SUBQ-1-k)*RW +: RW];
      nrank[k] = nb_cell[(NUM_SUBQ-1-k)*RW +: RW];
    end
  end

  assign unit_d    = CELL_W'(1) << ((NUM_SUBQ - 1 - int'(dsel[ROWW-1:0])) * RW);
  assign unit_e    = CELL_W'(1) << ((NUM_SUBQ - 1 - int'(esel[ROWW-1:0])) * RW);
  assign tw_addr   = {dsel[ROWW-1:0], wrank[dsel[ROWW-1:0]]};
  assign tw_last   = (dsel == DW'(NUM_SUBQ - 1));
  assign nb_last   = (dsel == DW'(NUM_SUBQ));
  assign e_last    = (esel == DW'(NUM_SUBQ));
  assign rank_room = (int'(crank[dsel[ROWW-1:0]]) + 1) < NUM_CLUSTERS;
  assign emit_ok   = (ptr < stop) && (32'(ptr) < ENTRY_DEPTH) && (emitted < want_cnt);
  assign ls_addr_b = LSW'(p_acc + 1'b1);
  assign want_sat  = (32'(in_data.want_count) > MAX_CANDIDATES) ?
                     CW'(MAX_CANDIDATES) : CW'(in_data.want_count);
  assign is_load   = accept && (in_data.mode != MODE_START);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_data.mode == MODE_START && want_sat != '0) state_next = S_CLEAR;
      end
      S_CLEAR:     if (clr_addr == (CELL_W+1)'(VCELLS - 1)) state_next = S_SEED;
      S_SEED:      state_next = S_TW_RD;
      S_TW_RD:     state_next = S_TW_ACC;
      S_TW_ACC: begin
        if (!tw_last) state_next = S_TW_RD;
        else state_next = for_pop ? S_LS_RD : S_PUSH;
      end
      S_PUSH:      state_next = S_PUSH_WAIT;
      S_PUSH_WAIT: if (!hstat.busy) state_next = seeding ? S_LOOP : S_NB_NEXT;
      S_LOOP: begin
        if (emitted == want_cnt) state_next = S_IDLE;
        else if (hstat.empty) state_next = S_END_MARK;
        else state_next = S_POP;
      end
      S_POP:       state_next = S_POP_WAIT;
      S_POP_WAIT:  if (!hstat.busy) state_next = S_MARK;
      S_MARK:      state_next = S_TW_RD;
      S_LS_RD:     state_next = S_LS_WAIT;
      S_LS_WAIT:   state_next = S_EMIT_CHK;
      S_EMIT_CHK:  state_next = emit_ok ? S_ENT_RD : S_NB_CHK;
      S_ENT_RD:    state_next = S_ENT_WAIT;
      S_ENT_WAIT:  if (slot_free) state_next = S_EMIT_CHK;
      S_NB_CHK: begin
        if (nb_last) state_next = S_LOOP;
        else state_next = rank_room ? S_VS_RD : S_NB_NEXT;
      end
      S_VS_RD:     if (e_last || nrank[esel[ROWW-1:0]] != '0) state_next = S_VS_CHK;
      S_VS_CHK: begin
        if (e_last) state_next = vis_rd ? S_NB_NEXT : S_TW_RD;
        else state_next = vis_rd ? S_VS_RD : S_NB_NEXT;
      end
      S_NB_NEXT:   state_next = S_NB_CHK;
      S_END_MARK:  if (slot_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    hreq.clear = accept && (in_data.mode == MODE_START);
    hreq.push  = (state == S_PUSH);
    hreq.pop   = (state == S_POP);
    vis_we     = (state == S_CLEAR) || (state == S_MARK);
    vis_wdata  = (state == S_MARK);
    vis_waddr  = (state == S_MARK) ? pop_cell : clr_addr[CELL_W-1:0];
    vis_raddr  = e_last ? nb_cell : nb_cell - unit_e;
  end

  msct_heap #(
    .NUM_SUBQ    (NUM_SUBQ),
    .NUM_CLUSTERS(NUM_CLUSTERS)
  ) u_heap (
    .clk     (clk),
    .rst     (rst),
    .req     (hreq),
    .key_in  (sum),
    .cell_in (walk_cell),
    .stat    (hstat),
    .top_cell(pop_cell)
  );

  // table memories: loads write, the walk reads through registered outputs
  always_ff @(posedge clk) begin
    if (is_load && in_data.mode == MODE_DIST && 32'(in_data.subq_row) < NUM_SUBQ &&
        32'(in_data.rank_column) < NUM_CLUSTERS)
      dist_mem[{in_data.subq_row[ROWW-1:0], in_data.rank_column[RW-1:0]}] <=
        in_data.distance_value;
    if (is_load && in_data.mode == MODE_ORDER && 32'(in_data.subq_row) < NUM_SUBQ &&
        32'(in_data.rank_column) < NUM_CLUSTERS && 32'(in_data.cluster_id) < NUM_CLUSTERS)
      ord_mem[{in_data.subq_row[ROWW-1:0], in_data.rank_column[RW-1:0]}] <=
        in_data.cluster_id[RW-1:0];
    if (is_load && in_data.mode == MODE_LIST && 32'(in_data.table_address) <= NCELLS)
      ls_mem[LSW'(in_data.table_address)] <= in_data.list_offset;
    if (is_load && in_data.mode == MODE_ENTRY && 32'(in_data.table_address) < ENTRY_DEPTH)
      ent_mem[EW'(in_data.table_address)] <= in_data.entry_value;
    dist_rd <= dist_mem[tw_addr];
    ord_rd  <= ord_mem[tw_addr];
    ls_rd_a <= ls_mem[p_acc];
    ls_rd_b <= ls_mem[ls_addr_b];
    ent_rd  <= ent_mem[EW'(ptr)];
  end

  // visited map
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_rd <= vis_mem[vis_raddr];
  end

  // control registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      emitted   <= '0;
      want_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && accept && in_data.mode == MODE_START) begin
        emitted  <= '0;
        want_cnt <= want_sat;
      end
      if ((state == S_ENT_WAIT || state == S_END_MARK) && slot_free) begin
        out_valid <= 1'b1;
        if (state == S_ENT_WAIT) emitted <= emitted + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (state == S_ENT_WAIT && slot_free) begin
      out_data.candidate <= ent_rd;
      out_data.last      <= (CW'(emitted + 1'b1) == want_cnt);
      out_data.exhausted <= 1'b0;
    end else if (state == S_END_MARK && slot_free) begin
      out_data.candidate <= '0;
      out_data.last      <= 1'b1;
      out_data.exhausted <= 1'b1;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:    clr_addr <= '0;
      S_CLEAR:   clr_addr <= clr_addr + 1'b1;
      S_SEED: begin
        walk_cell <= '0;
        dsel      <= '0;
        sum       <= '0;
        p_acc     <= '0;
        for_pop   <= 1'b0;
        seeding   <= 1'b1;
      end
      S_TW_ACC: begin
        sum   <= sum + KEY_W'(dist_rd);
        p_acc <= LSW'(p_acc * NUM_CLUSTERS) + LSW'(ord_rd);
        dsel  <= tw_last ? '0 : dsel + 1'b1;
      end
      S_PUSH_WAIT: begin
        if (!hstat.busy) begin
          seeding <= 1'b0;
          // back to the neighbor scan at the dimension that was pushed
          if (!seeding) dsel <= nb_d;
        end
      end
      S_MARK: begin
        walk_cell <= pop_cell;
        cur_cell  <= pop_cell;
        dsel      <= '0;
        sum       <= '0;
        p_acc     <= '0;
        for_pop   <= 1'b1;
      end
      S_LS_WAIT: begin
        ptr  <= ls_rd_a;
        stop <= ls_rd_b;
      end
      S_ENT_WAIT: if (slot_free) ptr <= ptr + 1'b1;
      S_NB_CHK: begin
        nb_cell <= cur_cell + unit_d;
        esel    <= '0;
      end
      S_VS_RD: if (!e_last && nrank[esel[ROWW-1:0]] == '0) esel <= esel + 1'b1;
      S_VS_CHK: begin
        if (!e_last && vis_rd) esel <= esel + 1'b1;
        // a neighbor's table walk starts at subquantizer 0
        if (e_last && !vis_rd) begin
          walk_cell <= nb_cell;
          dsel      <= '0;
          sum       <= '0;
          p_acc     <= '0;
          for_pop   <= 1'b0;
        end
      end
      S_NB_NEXT: dsel <= dsel + 1'b1;
      default: ;
    endcase
    // neighbor scan starts at subquantizer 0 after the list is done
    if (state == S_EMIT_CHK && !emit_ok) dsel <= '0;
  end

  // separate index for the neighbor scan while a neighbor's distance is summed
  always_ff @(posedge clk) begin
    if (state == S_VS_CHK && e_last && !vis_rd) nb_d <= dsel;
  end

  `MSCT_CHECK(a_pop_nonempty, state != S_POP || !hstat.empty)
  `MSCT_CHECK(a_emit_bound, emitted <= want_cnt)
  `MSCT_CHECK_NEXT(a_result_wait, state == S_ENT_WAIT && out_valid && !out_ready,
                   state == S_ENT_WAIT)
  `MSCT_CHECK(a_nb_index, state != S_NB_NEXT || 32'(dsel) < NUM_SUBQ)

endmodule

### dv/tb_multi_sequence_cell_traversal_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_sequence_cell_traversal_unit
// Table loads and start queries against a behavioral traversal predictor;
// candidates are checked field by field under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb_multi_sequence_cell_traversal_unit;
  import msct_pkg::*;

  localparam int NQ = NUM_SUBQ_DEF;
  localparam int NC = NUM_CLUSTERS_DEF;
  localparam int NCELL = NC * NC;
  localparam int EDEPTH = ENTRY_DEPTH_DEF;
  localparam int MAXC = MAX_CANDIDATES_DEF;
  localparam int IN_W = $bits(in_t);
  localparam logic [2:0] MODE_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  multi_sequence_cell_traversal_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor tables
  logic [15:0] dist_tab[NQ*NC];
  logic [3:0] order_tab[NQ*NC];
  logic [10:0] lstart_tab[NCELL+1];
  logic [31:0] entry_tab[EDEPTH];
  bit visited[NCELL];
  logic [17:0] hkey[NCELL];
  int hcell[NCELL];
  int hsize;

  in_t pending_beats[$];
  out_t expected_cands[$];
  int errors = 0;
  int ent_count = 0;
  bit hold_sender = 0;

  function automatic int rank_of(int cix, int d);
    return d == 0 ? cix / NC : cix % NC;
  endfunction

  function automatic int stride_of(int d);
    return d == 0 ? NC : 1;
  endfunction

  function automatic bit h_less(int a, int b);
    if (hkey[a] != hkey[b]) return hkey[a] < hkey[b];
    return hcell[a] < hcell[b];
  endfunction

  function automatic void h_swap(int a, int b);
    logic [17:0] k;
    int c;
    k = hkey[a]; c = hcell[a];
    hkey[a] = hkey[b]; hcell[a] = hcell[b];
    hkey[b] = k; hcell[b] = c;
  endfunction

  function automatic void h_push(int cix);
    int i;
    i = hsize++;
    hkey[i] = 18'(dist_tab[rank_of(cix, 0)]) + 18'(dist_tab[NC + rank_of(cix, 1)]);
    hcell[i] = cix;
    while (i > 0 && h_less(i, (i - 1) / 2)) begin
      h_swap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic int h_pop();
    int top, i, l, r, m;
    top = hcell[0];
    hsize--;
    hkey[0] = hkey[hsize]; hcell[0] = hcell[hsize];
    i = 0;
    forever begin
      l = 2 * i + 1; r = l + 1; m = i;
      if (l < hsize && h_less(l, m)) m = l;
      if (r < hsize && h_less(r, m)) m = r;
      if (m == i) break;
      h_swap(i, m);
      i = m;
    end
    return top;
  endfunction

  function automatic bit push_allowed(int cix);
    if (visited[cix]) return 0;
    for (int e = 0; e < NQ; e++)
      if (rank_of(cix, e) != 0 && !visited[cix - stride_of(e)]) return 0;
    return 1;
  endfunction

  // walk the cell grid and queue the candidates a start beat produces
  function automatic void predict_walk(in_t b);
    int want, emitted, cix, p, a, stop;
    out_t o;
    want = int'(b.want_count);
    if (want > MAXC) want = MAXC;
    if (want == 0) return;
    foreach (visited[i]) visited[i] = 0;
    hsize = 0;
    emitted = 0;
    h_push(0);
    while (emitted < want && hsize > 0) begin
      cix = h_pop();
      visited[cix] = 1;
      p = int'(order_tab[rank_of(cix, 0)]) * NC + int'(order_tab[NC + rank_of(cix, 1)]);
      a = int'(lstart_tab[p]);
      stop = int'(lstart_tab[p+1]);
      for (; a < stop && a < EDEPTH && emitted < want; a++) begin
        o = '0;
        o.candidate = entry_tab[a];
        o.last = (emitted + 1 == want);
        expected_cands.push_back(o);
        emitted++;
      end
      for (int d = 0; d < NQ; d++)
        if (rank_of(cix, d) + 1 < NC && push_allowed(cix + stride_of(d)))
          h_push(cix + stride_of(d));
    end
    if (emitted < want) begin
      o = '0;
      o.last = 1'b1;
      o.exhausted = 1'b1;
      expected_cands.push_back(o);
    end
  endfunction

  // apply one accepted beat to the predictor
  function automatic void predict_beat(in_t b);
    case (b.mode)
      MODE_DIST:
        if (b.subq_row < NQ && b.rank_column < NC)
          dist_tab[b.subq_row*NC + b.rank_column] = b.distance_value;
      MODE_ORDER:
        if (b.subq_row < NQ && b.rank_column < NC && b.cluster_id < NC)
          order_tab[b.subq_row*NC + b.rank_column] = b.cluster_id[3:0];
      MODE_LIST:
        if (b.table_address <= NCELL) lstart_tab[b.table_address] = b.list_offset;
      MODE_ENTRY:
        if (b.table_address < EDEPTH) entry_tab[b.table_address] = b.entry_value;
      MODE_START: predict_walk(b);
      default: ;
    endcase
  endfunction

  function automatic in_t rand_noise();
    in_t b;
    b = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    return b;
  endfunction

  function automatic in_t mk(logic [2:0] m, int row, int col, int val, int addr, int off,
                             logic [31:0] ent, int want);
    in_t b;
    b = rand_noise();
    b.mode = m;
    b.subq_row = 2'(row); b.rank_column = 8'(col); b.distance_value = 16'(val);
    b.cluster_id = 8'(val); b.table_address = 11'(addr); b.list_offset = 11'(off);
    b.entry_value = ent; b.want_count = 7'(want);
    return b;
  endfunction

  // full table fill: sorted distances, permuted orders, sparse lists, their entries
  task automatic queue_full_load(int max_dist, int list_cap);
    int acc, off, perm[NC], j, t;
    for (int d = 0; d < NQ; d++) begin
      acc = 0;
      for (int r = 0; r < NC; r++) begin
        acc += $urandom_range(max_dist, 0);
        if (acc > 65535) acc = 65535;
        pending_beats.push_back(mk(MODE_DIST, d, r, acc, 0, 0, 0, 0));
      end
      for (int r = 0; r < NC; r++) perm[r] = r;
      for (int r = NC - 1; r > 0; r--) begin
        j = $urandom_range(r, 0); t = perm[r]; perm[r] = perm[j]; perm[j] = t;
      end
      for (int r = 0; r < NC; r++) begin
        in_t b;
        b = mk(MODE_ORDER, d, r, perm[r], 0, 0, 0, 0);
        pending_beats.push_back(b);
      end
    end
    off = 0;
    for (int c = 0; c <= NCELL; c++) begin
      pending_beats.push_back(mk(MODE_LIST, 0, 0, 0, c, off, 0, 0));
      if (off < list_cap && $urandom_range(4, 0) == 0) off++;
    end
    ent_count = off;
    for (int a = 0; a < ent_count; a++)
      pending_beats.push_back(mk(MODE_ENTRY, 0, 0, 0, a, 0, $urandom, 0));
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_cands.size() != 0)
      @(posedge clk);
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_beat(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(20, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end else burst_left <= burst_left - 1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[8:7] == 2'd0) ? 1'b1 : ($urandom_range(3, 0) != 0);
      if (out_valid && out_ready) begin
        if (expected_cands.size() == 0) begin
          $display("%0t unexpected beat: actual %h", $time, out_data);
          errors++;
        end else begin
          out_t e;
          e = expected_cands.pop_front();
          if (e.candidate !== out_data.candidate || e.last !== out_data.last ||
              e.exhausted !== out_data.exhausted) begin
            $display("%0t mismatch: expected cand %h last %b exh %b, actual cand %h last %b exh %b",
                     $time, e.candidate, e.last, e.exhausted, out_data.candidate,
                     out_data.last, out_data.exhausted);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // fewer than 64 entries in all, so large requests run out of cells
    queue_full_load(300, 60);
    // directed queries: smallest, saturated, zero, maximum, unused mode, bad loads
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 1));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 127));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 64));
    pending_beats.push_back(mk(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 5));
    pending_beats.push_back(mk(3'd7, 3, 255, 65535, 2047, 2047, 32'hffffffff, 127));
    pending_beats.push_back(mk(MODE_DIST, 3, 255, 65535, 0, 0, 0, 0));
    pending_beats.push_back(mk(MODE_ORDER, 1, 2, 200, 0, 0, 0, 0));
    pending_beats.push_back(mk(MODE_LIST, 0, 0, 0, 2047, 5, 0, 0));
    pending_beats.push_back(mk(MODE_ENTRY, 0, 0, 0, 1024, 0, 32'hdeadbeef, 0));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 33));
    wait_drained();
    // hold the sender for a pause once all results are back
    hold_sender = 1;
    repeat (20) @(posedge clk);
    hold_sender = 0;
    // equal distances: ties in summed distance
    for (int d = 0; d < NQ; d++)
      for (int r = 0; r < NC; r++)
        pending_beats.push_back(mk(MODE_DIST, d, r, (r / 4) * 7, 0, 0, 0, 0));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 64));
    pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0, 3));
    wait_drained();
    // random part: updates and queries over the loaded tables
    for (int n = 0; n < 55; n++) begin
      int k;
      in_t b;
      k = $urandom_range(9, 0);
      if (k == 0) begin
        b = rand_noise();
        b.mode = 3'(5 + $urandom_range(2, 0));
        pending_beats.push_back(b);
      end
      else if (k == 1) pending_beats.push_back(mk(MODE_DIST, $urandom_range(1, 0),
                 $urandom_range(15, 0), $urandom_range(65535, 0), 0, 0, 0, 0));
      else if (k == 2) pending_beats.push_back(mk(MODE_ORDER, $urandom_range(1, 0),
                 $urandom_range(15, 0), $urandom_range(15, 0), 0, 0, 0, 0));
      else if (k == 3) pending_beats.push_back(mk(MODE_LIST, 0, 0, 0,
                 $urandom_range(NCELL, 0), $urandom_range(ent_count, 0), 0, 0));
      else if (k <= 5) pending_beats.push_back(mk(MODE_ENTRY, 0, 0, 0,
                 $urandom_range((ent_count > 0) ? ent_count - 1 : 0, 0), 0, $urandom, 0));
      else pending_beats.push_back(mk(MODE_START, 0, 0, 0, 0, 0, 0,
                 ($urandom_range(7, 0) == 0) ? $urandom_range(127, 0)
                                             : $urandom_range(12, 1)));
    end
    wait_drained();
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("PASS multi_sequence_cell_traversal_unit");
    else $display("FAIL multi_sequence_cell_traversal_unit");
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL multi_sequence_cell_traversal_unit");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/msct_pkg.sv
design/msct_heap.sv
design/multi_sequence_cell_traversal_unit.sv
dv/tb_multi_sequence_cell_traversal_unit.sv
